### rtl/set_of_stacks_engine_top_assert.svh
// Assertion macros for the set-of-stacks engine checker.
// Included by the checker file; needs nothing else.
`ifndef SET_OF_STACKS_ENGINE_TOP_ASSERT_SVH
`define SET_OF_STACKS_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SOS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sos_pkg.sv
// Shared types and codes of the set-of-stacks engine.
// No dependencies; used by the top level, sos_mem, sos_ctrl and sos_chk.
package sos_pkg;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_POP_AT = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
        logic [1:0]         stack_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

endpackage

### rtl/set_of_stacks_engine_top.sv
// Set-of-stacks engine: several equal stacks in one word store.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one operation per
//   transfer: push, pop from the current stack, or pop from a named stack.
//   Output channel (o_out_valid / i_out_ready / o_out_item) returns exactly one
//   result per operation, in order: popped word (zero otherwise) and a status
//   of ok, overflow or underflow.
// Sequence:
//   A push passes through S_PUSH, and also through S_PUSH_NEXT when it rolls
//   on to the next stack; a pop passes through S_POP and steps down over each
//   empty stack on its walk (at most NUM_STACKS - 1 of them); an unused
//   operation code or a pop-at beyond the stacks goes straight to the result.
//   A new transfer is taken in the cycle after the result leaves the sequencer,
//   so no new operation is taken before the last one is through. The pace is
//   set by the sequencer, which reads one fill count per cycle, and by the
//   registered read of the single-port word store.
// Stall:
//   The result sits in an output register, so the sequencer hands over a
//   result and takes the next item while the receiver holds i_out_ready low;
//   only a second finished result waits inside the sequencer.
// Reset (synchronous, active low): clear all fill counts, select stack 0,
//   drop any pending result. The word store is not cleared and needs no pass.
// Depends on sos_pkg, sos_ctrl and sos_mem.
module set_of_stacks_engine_top import sos_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int NUM_STACKS  = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int WORDS = NUM_STACKS * STACK_DEPTH;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    // sequencer result side
    logic      w_res_valid;
    logic      w_res_ready;
    t_out_item w_res_item;

    // word store port
    t_mem_cmd      w_mem_cmd;
    logic [AW-1:0] w_mem_addr;
    logic [31:0]   w_mem_wdata;
    logic [31:0]   w_mem_rdata;

    // output register
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      n_out_valid;

    sos_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_STACKS  (NUM_STACKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res_item  (w_res_item),
        .o_mem_cmd   (w_mem_cmd),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata)
    );

    sos_mem #(
        .DEPTH (WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_cmd   (w_mem_cmd),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // Take a new result when the register is empty or is being drained.
    assign w_res_ready = !r_out_valid || i_out_ready;
    assign n_out_valid = w_res_ready ? w_res_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (w_res_valid && w_res_ready) begin
            r_out_item <= w_res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/sos_mem.sv
// Word store of the set-of-stacks engine: one address port, registered read.
// Depends on sos_pkg for the command struct.
module sos_mem import sos_pkg::*; #(
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  t_mem_cmd      i_cmd,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sos_ctrl.sv
// Sequencer of the set-of-stacks engine: fill counts, current stack, walk-down.
// Depends on sos_pkg; drives the word store in sos_mem.
module sos_ctrl import sos_pkg::*; #(
    parameter int  STACK_DEPTH = 16,
    parameter int  NUM_STACKS  = 4,
    localparam int PW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1,
    localparam int FW = $clog2(STACK_DEPTH + 1),
    localparam int AW = (NUM_STACKS * STACK_DEPTH > 1) ?
                        $clog2(NUM_STACKS * STACK_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in_item      i_in_item,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_out_item     o_res_item,
    output t_mem_cmd      o_mem_cmd,
    output logic [AW-1:0] o_mem_addr,
    output logic [31:0]   o_mem_wdata,
    input  logic [31:0]   i_mem_rdata
);

    localparam logic [FW-1:0] DEPTH_C = FW'(STACK_DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(NUM_STACKS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_PUSH_NEXT,
        S_POP,
        S_RESULT
    } t_state;

    t_state          r_state;
    logic [PW-1:0]   r_ptr;
    logic [PW-1:0]   r_cur;
    logic [FW-1:0]   r_fill [NUM_STACKS];
    logic [31:0]     r_value;
    logic            r_walk;
    logic [1:0]      r_status;
    logic            r_from_mem;

    logic [FW-1:0]   w_fill;
    logic            w_has_room;
    logic            w_empty;
    logic            w_idx_ok;
    logic            w_idx_is_cur;
    logic [FW-1:0]   w_word_off;

    // single read port on the fill counts, steered by the stack pointer
    assign w_fill       = r_fill[r_ptr];
    assign w_has_room   = w_fill < DEPTH_C;
    assign w_empty      = w_fill == '0;
    assign w_idx_ok     = int'(i_in_item.stack_index) < NUM_STACKS;
    assign w_idx_is_cur = int'(i_in_item.stack_index) == int'(r_cur);
    assign w_word_off   = (r_state == S_POP) ? w_fill - FW'(1) : w_fill;

    assign o_mem_addr      = AW'(AW'(r_ptr) * AW'(STACK_DEPTH)) + AW'(w_word_off);
    assign o_mem_wdata     = r_value;
    assign o_mem_cmd.wr_en = (r_state == S_PUSH || r_state == S_PUSH_NEXT) && w_has_room;
    assign o_mem_cmd.rd_en = (r_state == S_POP) && !w_empty;

    assign o_in_ready        = r_state == S_IDLE;
    assign o_res_valid       = r_state == S_RESULT;
    assign o_res_item.data   = r_from_mem ? i_mem_rdata : '0;
    assign o_res_item.status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_ptr   <= '0;
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_value    <= i_in_item.value;
                        r_from_mem <= 1'b0;
                        r_status   <= ST_OK;
                        r_ptr      <= r_cur;
                        r_walk     <= 1'b1;
                        unique case (i_in_item.operation)
                            OP_PUSH: begin
                                r_state <= S_PUSH;
                            end
                            OP_POP: begin
                                r_state <= S_POP;
                            end
                            OP_POP_AT: begin
                                priority if (w_idx_is_cur) begin
                                    r_state <= S_POP;
                                end else if (w_idx_ok) begin
                                    r_ptr   <= PW'(i_in_item.stack_index);
                                    r_walk  <= 1'b0;
                                    r_state <= S_POP;
                                end else begin
                                    r_status <= ST_UNDERFLOW;
                                    r_state  <= S_RESULT;
                                end
                            end
                            default: begin
                                r_state <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_PUSH: begin
                    priority if (w_has_room) begin
                        r_fill[r_ptr] <= w_fill + FW'(1);
                        r_state       <= S_RESULT;
                    end else if (r_ptr == LAST_C) begin
                        r_status <= ST_OVERFLOW;
                        r_state  <= S_RESULT;
                    end else begin
                        r_ptr   <= r_ptr + PW'(1);
                        r_state <= S_PUSH_NEXT;
                    end
                end
                S_PUSH_NEXT: begin
                    if (w_has_room) begin
                        r_fill[r_ptr] <= w_fill + FW'(1);
                        r_cur         <= r_ptr;
                    end else begin
                        r_status <= ST_OVERFLOW;
                    end
                    r_state <= S_RESULT;
                end
                S_POP: begin
                    priority if (!w_empty) begin
                        r_fill[r_ptr] <= w_fill - FW'(1);
                        if (r_walk) begin
                            r_cur <= r_ptr;
                        end
                        r_from_mem <= 1'b1;
                        r_state    <= S_RESULT;
                    end else if (!r_walk || r_ptr == '0) begin
                        if (r_walk) begin
                            r_cur <= '0;
                        end
                        r_status <= ST_UNDERFLOW;
                        r_state  <= S_RESULT;
                    end else begin
                        r_ptr <= r_ptr - PW'(1);
                    end
                end
                S_RESULT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/sos_chk.sv
// Port-level checker for the set-of-stacks engine, bound to the top level.
// Depends on sos_pkg and set_of_stacks_engine_top_assert.svh.
`include "set_of_stacks_engine_top_assert.svh"

module sos_chk import sos_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // hold a result until it is taken
    `SOS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // the sequencer is busy right after a transfer
    `SOS_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready again one cycle after a transfer")

    // only ok results carry a popped word
    `SOS_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_out_item.status != ST_OK, o_out_item.data == '0, "failed operation returned data")

    // status is one of the three defined codes
    `SOS_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid, o_out_item.status == ST_OK || o_out_item.status == ST_OVERFLOW || o_out_item.status == ST_UNDERFLOW, "undefined status code")

endmodule

bind set_of_stacks_engine_top sos_chk u_sos_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
